// ----- rtl/core/deq_pkg.sv -----
// Shared types, constants and helpers of the double-ended queue.
`default_nettype none

package deq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the channel words.
  localparam int KIND_W   = 3;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  // Operation that every cell of the row performs at once.
  typedef enum logic [1:0] {
    CELL_HOLD        = 2'd0,
    CELL_SHIFT_RIGHT = 2'd1,
    CELL_SHIFT_LEFT  = 2'd2,
    CELL_LOAD_TAIL   = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    cnt_t     cnt;
  } cell_ctrl_t;

  // Stored entry to channel word, zero-extended or truncated.
  function automatic word_t to_word(data_t d);
    logic [63:0] wide;
    wide = 64'(d);
    return word_t'(wide[WORD_W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/deq_if.sv -----
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface deq_req_if;
  logic                          valid;
  logic                          ready;
  logic [deq_pkg::KIND_W-1:0]    kind;
  logic signed [deq_pkg::WORD_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface deq_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [deq_pkg::WORD_W-1:0]  popped_value;
  logic signed [deq_pkg::WORD_W-1:0]  front_value;
  logic signed [deq_pkg::WORD_W-1:0]  back_value;
  logic [deq_pkg::COUNT_W-1:0]        entry_count;
  logic [deq_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output popped_value, output front_value,
                  output back_value, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input popped_value, input front_value,
                  input back_value, input entry_count, input status,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/deq_cell.sv -----
// One storage cell of the queue row: holds an entry, shifts with its neighbors.
`default_nettype none

module deq_cell (
  input  wire logic                clk_i,
  input  wire deq_pkg::cell_ctrl_t ctrl_i,
  input  wire deq_pkg::cnt_t       pos_i,
  input  wire deq_pkg::data_t      value_i,
  input  wire deq_pkg::data_t      left_i,
  input  wire deq_pkg::data_t      right_i,
  output deq_pkg::data_t           data_o,
  output deq_pkg::data_t           tail_o
);
  import deq_pkg::*;

  data_t data_q, data_d;
  logic  is_tail;
  logic  is_free_head;

  assign is_tail      = (ctrl_i.cnt == (pos_i + CNT_W'(1)));
  assign is_free_head = (ctrl_i.cnt == pos_i);

  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      CELL_SHIFT_RIGHT: data_d = left_i;
      CELL_SHIFT_LEFT:  data_d = right_i;
      CELL_LOAD_TAIL: begin
        if (is_free_head) data_d = value_i;
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign tail_o = is_tail ? data_q : '0;

endmodule

`default_nettype wire

// ----- rtl/core/deq_row.sv -----
// Row of queue cells, front at cell 0, with the back-entry select.
`default_nettype none

module deq_row (
  input  wire logic                clk_i,
  input  wire deq_pkg::cell_ctrl_t ctrl_i,
  input  wire deq_pkg::data_t      value_i,
  output deq_pkg::data_t           front_o,
  output deq_pkg::data_t           back_o
);
  import deq_pkg::*;

  data_t data_w [DEPTH];
  data_t tail_w [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t left_w;
    data_t right_w;

    if (i == 0) begin : g_first
      assign left_w = value_i;
    end else begin : g_mid_l
      assign left_w = data_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = data_w[i+1];
    end

    deq_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .pos_i  (CNT_W'(i)),
      .value_i(value_i),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (data_w[i]),
      .tail_o (tail_w[i])
    );
  end

  // At most one cell flags itself as the tail.
  always_comb begin
    back_o = '0;
    for (int k = 0; k < DEPTH; k++) begin
      back_o = back_o | tail_w[k];
    end
  end

  assign front_o = data_w[0];

endmodule

`default_nettype wire

// ----- rtl/core/double_ended_queue.sv -----
// Top level of the double-ended queue: control, entry counter, response register.
//
// Usage:
//   req_i carries one word per operation: kind (push front, push back, pop
//   front, pop back, clear; codes 5..7 do nothing) and value for pushes.
//   rsp_o returns exactly one word per request: popped value (0 if no pop),
//   front and back values after the operation (0 when empty), entry count
//   and status (ok, underflow on pop when empty, overflow on push when full).
// Response: registered; it is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while rsp_o.ready stays high; the row of
//   cells shifts or loads on the accepted request, so nothing else limits the rate.
// Stall: while a response waits for rsp_o.ready, req_i.ready is low and the
//   queue state is frozen; a request is accepted in the same cycle the
//   pending response is taken.
// Reset: count and response valid return to zero; the queue comes up empty.
//   Cell contents are not reset, they are only read while occupied.
// Storage: entries sit in a row of cells with the front in cell 0. Push front
//   and pop front shift the whole row by one; push back loads the first free
//   cell; pop back only drops the count.
`default_nettype none

module double_ended_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  deq_req_if.sink   req_i,
  deq_rsp_if.source rsp_o
);
  import deq_pkg::*;

  cnt_t       cnt_q, cnt_d;
  logic       rsp_valid_q;
  word_t      popped_q, popped_d;
  status_e    status_q, status_d;
  cell_ctrl_t ctrl;
  cell_op_e   op_d;
  data_t      value;
  data_t      front_data;
  data_t      back_data;
  logic       accept;
  logic       empty;
  logic       full;
  kind_e      kind;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign kind        = kind_e'(req_i.kind);
  assign value       = data_t'(req_i.value);
  assign empty       = (cnt_q == '0);
  assign full        = (cnt_q == CNT_W'(DEPTH));

  // Decode the operation against the current fill level.
  always_comb begin
    cnt_d    = cnt_q;
    op_d     = CELL_HOLD;
    popped_d = '0;
    status_d = STATUS_OK;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (full) begin
          status_d = STATUS_OVERFLOW;
        end else begin
          op_d  = CELL_SHIFT_RIGHT;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      KIND_PUSH_BACK: begin
        if (full) begin
          status_d = STATUS_OVERFLOW;
        end else begin
          op_d  = CELL_LOAD_TAIL;
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          status_d = STATUS_UNDERFLOW;
        end else begin
          op_d     = CELL_SHIFT_LEFT;
          popped_d = to_word(front_data);
          cnt_d    = cnt_q - CNT_W'(1);
        end
      end
      KIND_POP_BACK: begin
        if (empty) begin
          status_d = STATUS_UNDERFLOW;
        end else begin
          popped_d = to_word(back_data);
          cnt_d    = cnt_q - CNT_W'(1);
        end
      end
      KIND_CLEAR: cnt_d = '0;
      default:    cnt_d = cnt_q;
    endcase
  end

  // Cells only move on an accepted request; they see the count before it.
  assign ctrl.op  = accept ? op_d : CELL_HOLD;
  assign ctrl.cnt = cnt_q;

  deq_row u_row (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .value_i(value),
    .front_o(front_data),
    .back_o (back_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) cnt_q <= cnt_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      popped_q <= popped_d;
      status_q <= status_d;
    end
  end

  // Front, back and count come straight from state, which is frozen while
  // the response waits.
  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.popped_value = popped_q;
  assign rsp_o.front_value  = empty ? '0 : to_word(front_data);
  assign rsp_o.back_value   = to_word(back_data);
  assign rsp_o.entry_count  = COUNT_W'(cnt_q);
  assign rsp_o.status       = status_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_cnt_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(cnt_q))
    else $error("entry count moved without a request");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !full && (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK)
    |=> cnt_q == $past(cnt_q) + CNT_W'(1))
    else $error("push did not add an entry");

  a_rsp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_valid_q)
    else $error("accepted request gave no response");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && empty |-> rsp_o.front_value == '0 && rsp_o.back_value == '0)
    else $error("empty queue shows an entry");

endmodule

`default_nettype wire
